// ===== src/sclru_pkg.sv =====
`default_nettype none

package sclru_pkg;

   // Default sizes of the cache. The default sector size is a power of two.
   localparam int SLOTS_DEFAULT        = 64;
   localparam int SECTOR_BYTES_DEFAULT = 32768;

   // Largest slot count supported; indices and counts are carried at this width.
   localparam int SLOTS_MAX  = 1024;
   localparam int SLOT_IDX_W = $clog2(SLOTS_MAX);
   localparam int SLOT_NUM_W = $clog2(SLOTS_MAX + 1);

   // Field widths.
   localparam int OFFSET_W     = 32;
   localparam int LENGTH_W     = 21;
   localparam int SLOT_INDEX_W = 6;
   localparam int IN_SLOT_W    = 15;
   localparam int CHUNK_LEN_W  = 16;
   localparam int DEST_W       = 20;
   localparam int STAMP_W      = 32;
   localparam int CFG_SLOTS_W  = 7;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOTS_IN_USE = '0;
   localparam logic [CFG_SLOTS_W-1:0] SLOTS_IN_USE_RESET = 7'd64;

   // Request conditioning.
   localparam logic [OFFSET_W-1:0] LOW_WINDOW = 32'h0000_8000;
   localparam logic [OFFSET_W-1:0] LOW_MASK   = 32'h0000_01FF;
   localparam logic [LENGTH_W-1:0] LENGTH_MAX = 21'h10_0000;

   // Chunk limit per request.
   localparam int MAX_RESULTS = 33;
   localparam int COUNT_W     = 6;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SCAN,
      ST_EMIT
   } sclru_state_type;

   // Search wave that travels along the cell row, one cell per cycle.
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_idx;
      logic                  stop;
      logic [STAMP_W-1:0]    low;
      logic [SLOT_IDX_W-1:0] best;
   } sclru_wave_type;

   // Values broadcast from the controller to every cell.
   typedef struct packed {
      logic [SLOT_NUM_W-1:0] n_active;
      logic [OFFSET_W-1:0]   sector;
      logic [STAMP_W-1:0]    stamp;
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_idx;
   } sclru_bcast_type;

endpackage

`default_nettype wire

// ===== src/sclru_if.sv =====
`default_nettype none

interface sclru_req_if;
   import sclru_pkg::*;

   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] rom_offset;
   logic [LENGTH_W-1:0] length;

   modport source (output valid, output rom_offset, output length, input ready);
   modport sink   (input valid, input rom_offset, input length, output ready);
endinterface

interface sclru_rsp_if;
   import sclru_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SLOT_INDEX_W-1:0] slot_index;
   logic [IN_SLOT_W-1:0]    offset_in_slot;
   logic [CHUNK_LEN_W-1:0]  chunk_length;
   logic [DEST_W-1:0]       dest_offset;
   logic                    fill_needed;
   logic [OFFSET_W-1:0]     sector_base;
   logic                    last_chunk;

   modport source (output valid, output slot_index, output offset_in_slot,
                   output chunk_length, output dest_offset, output fill_needed,
                   output sector_base, output last_chunk, input ready);
   modport sink   (input valid, input slot_index, input offset_in_slot,
                   input chunk_length, input dest_offset, input fill_needed,
                   input sector_base, input last_chunk, output ready);
endinterface

`default_nettype wire

// ===== src/sector_cache_lru_lookup.sv =====
// Each chunk runs a launch state, then a hop through each of the SLOTS cells; its result is
// registered and then shown. One request is handled at a time: a request of several chunks
// holds the input until its last chunk is taken, and the next chunk is not launched until the
// previous result is taken. A request with a zero offset or zero length is taken in ST_IDLE
// and leaves the block idle.
// Reset (synchronous, active high) invalidates every slot, clears stamps and the access counter,
// and sets slots_in_use to 64; no clearing pass is needed.
`default_nettype none

module sector_cache_lru_lookup #(
   parameter int SLOTS        = sclru_pkg::SLOTS_DEFAULT,
   parameter int SECTOR_BYTES = sclru_pkg::SECTOR_BYTES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sclru_req_if.sink                              req_chan,
   sclru_rsp_if.source                            rsp_chan,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [sclru_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [sclru_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [sclru_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                   pready
);
   import sclru_pkg::*;

   // The sector size must be a power of two; the block itself does not check it. The offset
   // within a sector is then simply the low bits of the address.
   localparam int WITHIN_W = $clog2(SECTOR_BYTES);
   localparam logic [LENGTH_W-1:0] SECTOR_LEN = LENGTH_W'(SECTOR_BYTES);
   localparam logic [COUNT_W-1:0]  COUNT_LAST = COUNT_W'(MAX_RESULTS - 1);

   // Control state.
   sclru_state_type         state_ff, state_in;
   logic [STAMP_W-1:0]      stamp_ff, stamp_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [CFG_SLOTS_W-1:0]  slots_reg_ff, slots_reg_in;

   // Working registers of the current request.
   logic [OFFSET_W-1:0]     src_ff, src_in;
   logic [LENGTH_W-1:0]     len_ff, len_in;
   logic [DEST_W-1:0]       dst_ff, dst_in;
   logic [LENGTH_W-1:0]     part_ff, part_in;

   // Result register.
   logic [SLOT_INDEX_W-1:0] out_slot_ff;
   logic [IN_SLOT_W-1:0]    out_within_ff;
   logic [CHUNK_LEN_W-1:0]  out_len_ff;
   logic [DEST_W-1:0]       out_dest_ff;
   logic                    out_fill_ff;
   logic [OFFSET_W-1:0]     out_sector_ff;
   logic                    last_ff;
   logic                    load_rsp;

   // Combinational helpers.
   logic [OFFSET_W-1:0]     src_new;
   logic [LENGTH_W-1:0]     len_new;
   logic [WITHIN_W-1:0]     sec_off;
   logic [LENGTH_W-1:0]     room, part, len_left;
   logic [OFFSET_W-1:0]     sector;
   logic                    last_now;
   logic [SLOT_NUM_W-1:0]   n_active;
   logic                    csr_write;
   logic [CSR_IDX_W-1:0]    csr_idx;

   logic                    launch;
   logic                    wr_en;
   logic                    scan_done;
   logic                    scan_hit;
   logic [SLOT_IDX_W-1:0]   scan_slot;
   sclru_bcast_type         bcast;

   // ---------------------------------------------------------------------------------------
   // Register port. Only slots_in_use exists; writes elsewhere are ignored.
   // ---------------------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      slots_reg_in = slots_reg_ff;
      if (csr_write && (csr_idx == REG_SLOTS_IN_USE)) begin
         slots_reg_in = pwdata[CFG_SLOTS_W-1:0];
      end
   end

   assign prdata = (csr_idx == REG_SLOTS_IN_USE) ? CSR_DATA_W'(slots_reg_ff) : '0;

   // A count of zero behaves as one slot, and anything above the built size as all of them.
   always_comb begin
      if (slots_reg_ff == '0) begin
         n_active = SLOT_NUM_W'(1);
      end else if (int'(slots_reg_ff) > SLOTS) begin
         n_active = SLOT_NUM_W'(SLOTS);
      end else begin
         n_active = SLOT_NUM_W'(slots_reg_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Request conditioning: offsets in the low window are folded to the window base plus
   // their low nine bits, and the length is clipped to one mebibyte.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      src_new = req_chan.rom_offset;
      if (req_chan.rom_offset <= LOW_WINDOW) begin
         src_new = LOW_WINDOW + (req_chan.rom_offset & LOW_MASK);
      end
      len_new = (req_chan.length > LENGTH_MAX) ? LENGTH_MAX : req_chan.length;
   end

   // Chunk arithmetic on the current address and remaining length.
   assign sec_off  = src_ff[WITHIN_W-1:0];
   assign room     = SECTOR_LEN - LENGTH_W'(sec_off);
   assign part     = (len_ff > room) ? room : len_ff;
   assign len_left = len_ff - part;
   assign sector   = src_ff - OFFSET_W'(sec_off);
   assign last_now = (len_left == '0) || (count_ff == COUNT_LAST);

   // ---------------------------------------------------------------------------------------
   // Cell row. The chosen slot is rewritten with the sector and current stamp in the cycle
   // the wave leaves the last cell, whether the chunk hit or missed.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      bcast          = '0;
      bcast.n_active = n_active;
      bcast.sector   = sector;
      bcast.stamp    = stamp_ff;
      bcast.wr_en    = wr_en;
      bcast.wr_idx   = scan_slot;
   end

   sclru_chain #(
      .SLOTS (SLOTS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .launch    (launch),
      .bcast     (bcast),
      .scan_done (scan_done),
      .scan_hit  (scan_hit),
      .scan_slot (scan_slot)
   );

   // ---------------------------------------------------------------------------------------
   // Sequencer. Each chunk runs launch and scan, then holds its result until the output
   // transaction completes. The access stamp is bumped once per request and once for
   // every further chunk; a zero offset leaves it alone.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      stamp_in   = stamp_ff;
      count_in   = count_ff;
      src_in     = src_ff;
      len_in     = len_ff;
      dst_in     = dst_ff;
      part_in    = part_ff;
      launch     = 1'b0;
      wr_en      = 1'b0;
      load_rsp   = 1'b0;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid && (req_chan.rom_offset != '0)) begin
               stamp_in   = stamp_ff + STAMP_W'(1);
               src_in     = src_new;
               len_in     = len_new;
               dst_in     = '0;
               count_in   = '0;
               if (len_new != '0) begin
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: begin
            launch   = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               wr_en    = 1'b1;
               load_rsp = 1'b1;
               len_in   = len_left;
               part_in  = part;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               count_in = count_ff + COUNT_W'(1);
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  src_in     = src_ff + OFFSET_W'(part_ff);
                  dst_in     = dst_ff + DEST_W'(part_ff);
                  stamp_in   = stamp_ff + STAMP_W'(1);
                  state_in   = ST_LAUNCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stamp_ff     <= '0;
         count_ff     <= '0;
         slots_reg_ff <= SLOTS_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         stamp_ff     <= stamp_in;
         count_ff     <= count_in;
         slots_reg_ff <= slots_reg_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      len_ff     <= len_in;
      dst_ff     <= dst_in;
      part_ff    <= part_in;
      if (load_rsp) begin
         out_slot_ff   <= SLOT_INDEX_W'(scan_slot);
         out_within_ff <= IN_SLOT_W'(sec_off);
         out_len_ff    <= CHUNK_LEN_W'(part);
         out_dest_ff   <= dst_ff;
         out_fill_ff   <= !scan_hit;
         out_sector_ff <= sector;
         last_ff       <= last_now;
      end
   end

   assign rsp_chan.slot_index     = out_slot_ff;
   assign rsp_chan.offset_in_slot = out_within_ff;
   assign rsp_chan.chunk_length   = out_len_ff;
   assign rsp_chan.dest_offset    = out_dest_ff;
   assign rsp_chan.fill_needed    = out_fill_ff;
   assign rsp_chan.sector_base    = out_sector_ff;
   assign rsp_chan.last_chunk     = last_ff;

endmodule

`default_nettype wire

// ===== src/sclru_cell.sv =====
`default_nettype none

module sclru_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sclru_pkg::sclru_bcast_type bcast,
   input  wire sclru_pkg::sclru_wave_type  wave_i,
   output sclru_pkg::sclru_wave_type       wave_o
);
   import sclru_pkg::*;

   localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(INDEX);
   localparam logic [SLOT_NUM_W-1:0] MY_NUM = SLOT_NUM_W'(INDEX);

   logic [OFFSET_W-1:0] tag_ff, tag_in;
   logic                valid_ff, valid_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   sclru_wave_type      wave_ff, wave_in;
   logic                active;

   assign active = (MY_NUM < bcast.n_active);

   // Cells beyond the active count pass the wave on untouched.
   always_comb begin
      wave_in = wave_i;
      if (wave_i.valid && active) begin
         if (!wave_i.hit && valid_ff && (tag_ff == bcast.sector)) begin
            wave_in.hit     = 1'b1;
            wave_in.hit_idx = MY_IDX;
         end
         if (!wave_i.stop && (stamp_ff <= wave_i.low)) begin
            wave_in.low  = stamp_ff;
            wave_in.best = MY_IDX;
            if (stamp_ff == '0) begin
               wave_in.stop = 1'b1;
            end
         end
      end
   end

   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      stamp_in = stamp_ff;
      if (bcast.wr_en && (bcast.wr_idx == MY_IDX)) begin
         tag_in   = bcast.sector;
         valid_in = 1'b1;
         stamp_in = bcast.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         stamp_ff <= stamp_in;
         wave_ff  <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign wave_o = wave_ff;

endmodule

`default_nettype wire

// ===== src/sclru_chain.sv =====
`default_nettype none

module sclru_chain #(
   parameter int SLOTS = sclru_pkg::SLOTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             launch,
   input  wire sclru_pkg::sclru_bcast_type       bcast,
   output logic                                  scan_done,
   output logic                                  scan_hit,
   output logic [sclru_pkg::SLOT_IDX_W-1:0]      scan_slot
);
   import sclru_pkg::*;

   sclru_wave_type wave [SLOTS+1];

   // A fresh wave starts with the running minimum at the current stamp.
   always_comb begin
      wave[0]         = '0;
      wave[0].valid   = launch;
      wave[0].low     = bcast.stamp;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      sclru_cell #(
         .INDEX (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .bcast  (bcast),
         .wave_i (wave[i]),
         .wave_o (wave[i+1])
      );
   end

   assign scan_done = wave[SLOTS].valid;
   assign scan_hit  = wave[SLOTS].hit;
   assign scan_slot = wave[SLOTS].hit ? wave[SLOTS].hit_idx : wave[SLOTS].best;

endmodule

`default_nettype wire

// ===== src/sclru_checker.sv =====
`default_nettype none

module sclru_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic [sclru_pkg::OFFSET_W-1:0]     req_rom_offset,
   input wire logic [sclru_pkg::LENGTH_W-1:0]     req_length,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [sclru_pkg::SLOT_INDEX_W-1:0] rsp_slot_index,
   input wire logic [sclru_pkg::IN_SLOT_W-1:0]    rsp_offset_in_slot,
   input wire logic [sclru_pkg::CHUNK_LEN_W-1:0]  rsp_chunk_length,
   input wire logic [sclru_pkg::DEST_W-1:0]       rsp_dest_offset,
   input wire logic                               rsp_fill_needed,
   input wire logic [sclru_pkg::OFFSET_W-1:0]     rsp_sector_base,
   input wire logic                               rsp_last_chunk
);
   import sclru_pkg::*;

   logic req_take;
   logic req_empty;

   assign req_take  = req_valid && req_ready;
   assign req_empty = (req_rom_offset == '0) || (req_length == '0);

   // A pending result holds still until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_slot_index, rsp_offset_in_slot, rsp_chunk_length, rsp_dest_offset,
                  rsp_fill_needed, rsp_sector_base, rsp_last_chunk}))
      else $error("result changed while stalled");

   // No new request is taken while a result of the current one is pending.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   // A request with nothing to copy leaves the block ready at once.
   a_empty_request: assert property (@(posedge clock) disable iff (reset)
      req_take && req_empty |=> req_ready && !rsp_valid)
      else $error("empty request did not return to idle");

   // A real request makes the block busy, with no result in the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_empty |=> !req_ready && !rsp_valid)
      else $error("block not busy after a request");

   // Nothing follows the final chunk of a request.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_chunk |=> !rsp_valid && req_ready)
      else $error("result after the final chunk");

endmodule

bind sector_cache_lru_lookup sclru_checker u_sclru_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_rom_offset     (req_chan.rom_offset),
   .req_length         (req_chan.length),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_slot_index     (rsp_chan.slot_index),
   .rsp_offset_in_slot (rsp_chan.offset_in_slot),
   .rsp_chunk_length   (rsp_chan.chunk_length),
   .rsp_dest_offset    (rsp_chan.dest_offset),
   .rsp_fill_needed    (rsp_chan.fill_needed),
   .rsp_sector_base    (rsp_chan.sector_base),
   .rsp_last_chunk     (rsp_chan.last_chunk)
);

`default_nettype wire
